[hw/rtl/chrg_pkg.sv]
package chrg_pkg;

  // CORDIC defaults and arctangent table in units of 2^-32 turn.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [29:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_T_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_MAX = 2'd1;
  localparam logic [30:0] T_MIN_RST = 31'd6554;
  localparam logic [30:0] T_MAX_RST = 31'd655360;

  // A three-component Q.30 vector.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // Q.30 product, rounded to nearest with ties toward +infinity.
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

[hw/rtl/cosine_hemisphere_ray_generator.sv]
// Cosine-weighted hemisphere ray generator. Each input beat (surface point, normal in Q2.14,
// two uniform Q0.16 numbers) yields exactly one output beat: the point as origin, a unit
// direction in Q2.14 drawn around the normalized normal, and t_min/t_max from the two
// configuration registers. The block is a single fully pipelined datapath that takes one
// beat every cycle while the output is not stalled. The CORDIC lies off the longest path,
// so CORDIC_STEPS does not lengthen it. The chain's root and divide units work one bit per
// stage: the normal's length root (24 stages), the normalizing divide (31), the basis
// reciprocal divide (31), the direction length root (24) and the final divide (16). An
// output stall freezes the whole pipeline, so in_stall follows out_stall while the output
// register is full. Configuration writes are accepted in any cycle and should be made
// while the pipeline is empty.
module cosine_hemisphere_ray_generator
  import chrg_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  input  logic signed [31:0]    in_point_z,
  input  logic signed [15:0]    in_normal_x,
  input  logic signed [15:0]    in_normal_y,
  input  logic signed [15:0]    in_normal_z,
  input  logic [15:0]           in_uniform_angle,
  input  logic [15:0]           in_uniform_elevation,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_origin_x,
  output logic signed [31:0]    out_origin_y,
  output logic signed [31:0]    out_origin_z,
  output logic signed [15:0]    out_dir_x,
  output logic signed [15:0]    out_dir_y,
  output logic signed [15:0]    out_dir_z,
  output logic [30:0]           out_t_min,
  output logic [30:0]           out_t_max,
  output logic                  out_zero_normal,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Unit sizes and stage timing (cycle index at which each register holds a beat).
  localparam int NL_W  = 48;
  localparam int NL_RW = NL_W / 2;
  localparam int NQ_W  = 31;
  localparam int AQ_W  = 31;
  localparam int TS_W  = 62;
  localparam int TS_RW = TS_W / 2;
  localparam int DL_W  = 48;
  localparam int DL_RW = DL_W / 2;
  localparam int DQ_W  = 16;
  localparam int CS_LAT = ((CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS) + 1;

  localparam int T_P0  = 1;
  localparam int T_SQ  = T_P0 + 1;
  localparam int T_L   = T_SQ + NL_RW;
  localparam int T_NUM = T_L + 1;
  localparam int T_N   = T_NUM + NQ_W;
  localparam int T_NR  = T_N + 1;
  localparam int T_PR  = T_NR + 1;
  localparam int T_AD  = T_NR + 1;
  localparam int T_AQ  = T_AD + AQ_W;
  localparam int T_A   = T_AQ + 1;
  localparam int T_M   = T_A + 1;
  localparam int T_B   = T_M + 1;
  localparam int T_E   = T_B + 1;
  localparam int T_S   = T_E + 1;
  localparam int T_R   = T_S + 1;
  localparam int T_RQ  = T_R + 1;
  localparam int T_RS  = T_RQ + 1;
  localparam int T_DL  = T_RS + DL_RW;
  localparam int T_DN  = T_DL + 1;
  localparam int T_DQ  = T_DN + DQ_W;
  localparam int T_OUT = T_DQ + 1;
  localparam int T_CS  = T_P0 + CS_LAT;
  localparam int T_CT  = T_P0 + TS_RW;
  localparam int T_TAN = T_CT + 1;

  // Direction divide numerator: {too_big, numerator}.
  function automatic logic [38:0] dir_num(input logic signed [33:0] e,
                                          input logic [23:0] dl);
    logic [33:0] ae;
    logic [37:0] m;
    logic        big;
    ae  = e[33] ? 34'(-e) : 34'(e);
    m   = {ae, 4'b0000} + 38'(dl >> 1);
    big = {2'b00, m} >= {dl, 16'h0000};
    return {big, big ? 38'd0 : m};
  endfunction

  // Apply sign and clamp to the signed 16-bit range.
  function automatic logic [15:0] dir_sat(input logic [15:0] q, input logic big,
                                          input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (big || q[15]) ? 16'h7FFF : q;
    end else begin
      r = (big || q > 16'h8000) ? 16'h8000 : 16'(-q);
    end
    return r;
  endfunction

  logic                  adv;
  logic [T_OUT-1:0]      vld_r;
  logic [30:0]           t_min_r, t_max_r;

  vec_t                  pt_r;
  logic signed [15:0]    nvx_r, nvy_r, nvz_r;
  logic [15:0]           u1_r, u2_r;
  logic [31:0]           sq_r;
  logic [NL_RW-1:0]      nl_q;
  logic [47:0]           nv_d;
  logic signed [15:0]    vdx, vdy, vdz;
  logic [15:0]           avx, avy, avz;
  logic [53:0]           nnx_r, nny_r, nnz_r;
  logic [NL_RW-1:0]      nden_r;
  logic [2:0]            nsgn_r, nsgn_d;
  logic [NQ_W-1:0]       nqx, nqy, nqz;
  vec_t                  n_r, n_m, n_b_r;
  logic signed [31:0]    pxy_r, pxx_r, pyy_r;
  logic [95:0]           pp_d;
  logic signed [31:0]    pxy_d, pxx_d, pyy_d;
  logic [31:0]           anz, aden_nxt;
  logic [31:0]           aden_r;
  logic [60:0]           anum_r;
  logic                  zneg_d;
  logic [AQ_W-1:0]       aq;
  logic signed [31:0]    a_r;
  logic signed [31:0]    b_r, mxx_r, myy_r;
  vec_t                  b1_r, b2_r;

  logic signed [31:0]    cp_q, sp_q;
  logic [63:0]           cs_d;
  logic signed [31:0]    cp_d, sp_d;
  logic [TS_RW-1:0]      ct_q, st_q;
  logic [16:0]           u2c;
  logic signed [31:0]    tx_r, ty_r, ct_r;
  logic [95:0]           tan_d;
  logic signed [31:0]    tx_b, ty_b, ct_b;

  vec_t                  e1_r, e2_r, e3_r;
  logic signed [33:0]    ex_r, ey_r, ez_r;
  logic signed [33:0]    erx, ery, erz;
  logic signed [23:0]    rx_r, ry_r, rz_r;
  logic [47:0]           qx_r, qy_r, qz_r;
  logic [47:0]           rs_r;
  logic [DL_RW-1:0]      dl_q;
  logic [101:0]          e_d;
  logic signed [33:0]    edx, edy, edz;
  logic [38:0]           dnx, dny, dnz;
  logic [37:0]           dnx_r, dny_r, dnz_r;
  logic [DL_RW-1:0]      dden_r;
  logic [6:0]            dflg_r, dflg_d;
  logic [DQ_W-1:0]       dqx, dqy, dqz;
  logic                  zn_d;
  logic [95:0]           pt_d;
  vec_t                  pt_o;

  vec_t                  org_r;
  logic [15:0]           dir_x_r, dir_y_r, dir_z_r;
  logic [30:0]           ot_min_r, ot_max_r;
  logic                  zn_r;

  // The pipeline advances as one whenever the output register can move.
  assign adv      = !vld_r[T_OUT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[T_OUT-2:0], in_valid};
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_min_r <= T_MIN_RST;
      t_max_r <= T_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_T_MIN: t_min_r <= cfg_data[30:0];
        REG_T_MAX: t_max_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Input register and squared normal length.
  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r.x <= in_point_x;
      pt_r.y <= in_point_y;
      pt_r.z <= in_point_z;
      nvx_r  <= in_normal_x;
      nvy_r  <= in_normal_y;
      nvz_r  <= in_normal_z;
      u1_r   <= in_uniform_angle;
      u2_r   <= in_uniform_elevation;
      sq_r   <= 32'(nvx_r) * 32'(nvx_r) + 32'(nvy_r) * 32'(nvy_r)
                + 32'(nvz_r) * 32'(nvz_r);
    end
  end

  // Normal length in Q.22.
  chrg_isqrt #(.W(NL_W)) u_nlen (
    .clk (clk), .en (adv), .rad ({sq_r, 16'h0000}), .root (nl_q)
  );

  chrg_delay #(.W(48), .DEPTH(T_L - T_P0)) u_nv_dly (
    .clk (clk), .en (adv), .d ({nvx_r, nvy_r, nvz_r}), .q (nv_d)
  );

  assign vdx = nv_d[47:32];
  assign vdy = nv_d[31:16];
  assign vdz = nv_d[15:0];
  assign avx = vdx[15] ? 16'(-vdx) : vdx;
  assign avy = vdy[15] ? 16'(-vdy) : vdy;
  assign avz = vdz[15] ? 16'(-vdz) : vdz;

  // Rounded numerators for normal / length.
  always_ff @(posedge clk) begin
    if (adv) begin
      nnx_r  <= {avx, 38'd0} + 54'(nl_q >> 1);
      nny_r  <= {avy, 38'd0} + 54'(nl_q >> 1);
      nnz_r  <= {avz, 38'd0} + 54'(nl_q >> 1);
      nden_r <= nl_q;
      nsgn_r <= {vdx[15], vdy[15], vdz[15]};
    end
  end

  chrg_div #(.NW(54), .DW(NL_RW), .QW(NQ_W)) u_ndiv_x (
    .clk (clk), .en (adv), .num (nnx_r), .den (nden_r), .quo (nqx)
  );
  chrg_div #(.NW(54), .DW(NL_RW), .QW(NQ_W)) u_ndiv_y (
    .clk (clk), .en (adv), .num (nny_r), .den (nden_r), .quo (nqy)
  );
  chrg_div #(.NW(54), .DW(NL_RW), .QW(NQ_W)) u_ndiv_z (
    .clk (clk), .en (adv), .num (nnz_r), .den (nden_r), .quo (nqz)
  );

  chrg_delay #(.W(3), .DEPTH(T_N - T_NUM)) u_nsgn_dly (
    .clk (clk), .en (adv), .d (nsgn_r), .q (nsgn_d)
  );

  // Signed unit normal, its products, and the basis reciprocal operands.
  assign anz      = n_r.z[31] ? 32'(-n_r.z) : 32'(n_r.z);
  assign aden_nxt = 32'h4000_0000 + anz;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r.x  <= nsgn_d[2] ? -$signed({1'b0, nqx}) : $signed({1'b0, nqx});
      n_r.y  <= nsgn_d[1] ? -$signed({1'b0, nqy}) : $signed({1'b0, nqy});
      n_r.z  <= nsgn_d[0] ? -$signed({1'b0, nqz}) : $signed({1'b0, nqz});
      pxy_r  <= mul30(n_r.x, n_r.y);
      pxx_r  <= mul30(n_r.x, n_r.x);
      pyy_r  <= mul30(n_r.y, n_r.y);
      aden_r <= aden_nxt;
      anum_r <= {1'b1, 60'd0} + 61'(aden_nxt >> 1);
    end
  end

  chrg_div #(.NW(61), .DW(32), .QW(AQ_W)) u_adiv (
    .clk (clk), .en (adv), .num (anum_r), .den (aden_r), .quo (aq)
  );

  chrg_delay #(.W(1), .DEPTH(T_AQ - T_NR)) u_zneg_dly (
    .clk (clk), .en (adv), .d (n_r.z[31]), .q (zneg_d)
  );

  chrg_delay #(.W(96), .DEPTH(T_A - T_PR)) u_pp_dly (
    .clk (clk), .en (adv), .d ({pxy_r, pxx_r, pyy_r}), .q (pp_d)
  );

  assign pxy_d = pp_d[95:64];
  assign pxx_d = pp_d[63:32];
  assign pyy_d = pp_d[31:0];

  chrg_delay #(.W(96), .DEPTH(T_M - T_NR)) u_n_dly (
    .clk (clk), .en (adv), .d (n_r), .q (n_m)
  );

  // Branchless basis: a = -s / (1 + |nz|), then b1 and b2.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= zneg_d ? $signed({1'b0, aq}) : -$signed({1'b0, aq});
      b_r   <= mul30(pxy_d, a_r);
      mxx_r <= mul30(pxx_d, a_r);
      myy_r <= mul30(pyy_d, a_r);
      n_b_r <= n_m;
      b2_r.x <= b_r;
      b2_r.z <= -n_m.y;
      if (!n_m.z[31]) begin
        b1_r.x <= 32'sh4000_0000 + mxx_r;
        b1_r.y <= b_r;
        b1_r.z <= -n_m.x;
        b2_r.y <= 32'sh4000_0000 + myy_r;
      end else begin
        b1_r.x <= 32'sh4000_0000 - mxx_r;
        b1_r.y <= -b_r;
        b1_r.z <= n_m.x;
        b2_r.y <= myy_r - 32'sh4000_0000;
      end
    end
  end

  // Azimuth and elevation of the local direction.
  chrg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk (clk), .en (adv), .angle (u1_r), .cos_o (cp_q), .sin_o (sp_q)
  );

  assign u2c = 17'h10000 - {1'b0, u2_r};

  chrg_isqrt #(.W(TS_W)) u_cos_t (
    .clk (clk), .en (adv), .rad ({2'b00, u2_r, 44'd0}), .root (ct_q)
  );
  chrg_isqrt #(.W(TS_W)) u_sin_t (
    .clk (clk), .en (adv), .rad ({1'b0, u2c, 44'd0}), .root (st_q)
  );

  chrg_delay #(.W(64), .DEPTH(T_CT - T_CS)) u_cs_dly (
    .clk (clk), .en (adv), .d ({cp_q, sp_q}), .q (cs_d)
  );

  assign cp_d = cs_d[63:32];
  assign sp_d = cs_d[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= mul30($signed({1'b0, st_q}), cp_d);
      ty_r <= mul30($signed({1'b0, st_q}), sp_d);
      ct_r <= $signed({1'b0, ct_q});
    end
  end

  chrg_delay #(.W(96), .DEPTH(T_B - T_TAN)) u_tan_dly (
    .clk (clk), .en (adv), .d ({tx_r, ty_r, ct_r}), .q (tan_d)
  );

  assign tx_b = tan_d[95:64];
  assign ty_b = tan_d[63:32];
  assign ct_b = tan_d[31:0];

  // Rotate into world space, then reduce to Q.20 for the length.
  assign erx = ex_r + 34'sd512;
  assign ery = ey_r + 34'sd512;
  assign erz = ez_r + 34'sd512;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r.x <= mul30(tx_b, b1_r.x);
      e1_r.y <= mul30(tx_b, b1_r.y);
      e1_r.z <= mul30(tx_b, b1_r.z);
      e2_r.x <= mul30(ty_b, b2_r.x);
      e2_r.y <= mul30(ty_b, b2_r.y);
      e2_r.z <= mul30(ty_b, b2_r.z);
      e3_r.x <= mul30(ct_b, n_b_r.x);
      e3_r.y <= mul30(ct_b, n_b_r.y);
      e3_r.z <= mul30(ct_b, n_b_r.z);
      ex_r   <= 34'(e1_r.x) + 34'(e2_r.x) + 34'(e3_r.x);
      ey_r   <= 34'(e1_r.y) + 34'(e2_r.y) + 34'(e3_r.y);
      ez_r   <= 34'(e1_r.z) + 34'(e2_r.z) + 34'(e3_r.z);
      rx_r   <= erx[33:10];
      ry_r   <= ery[33:10];
      rz_r   <= erz[33:10];
      qx_r   <= 48'(rx_r) * 48'(rx_r);
      qy_r   <= 48'(ry_r) * 48'(ry_r);
      qz_r   <= 48'(rz_r) * 48'(rz_r);
      rs_r   <= qx_r + qy_r + qz_r;
    end
  end

  chrg_isqrt #(.W(DL_W)) u_dlen (
    .clk (clk), .en (adv), .rad (rs_r), .root (dl_q)
  );

  chrg_delay #(.W(102), .DEPTH(T_DL - T_S)) u_e_dly (
    .clk (clk), .en (adv), .d ({ex_r, ey_r, ez_r}), .q (e_d)
  );

  assign edx = e_d[101:68];
  assign edy = e_d[67:34];
  assign edz = e_d[33:0];
  assign dnx = dir_num(edx, dl_q);
  assign dny = dir_num(edy, dl_q);
  assign dnz = dir_num(edz, dl_q);

  // Direction divide operands; flags are {neg x,y,z, big x,y,z, zero length}.
  always_ff @(posedge clk) begin
    if (adv) begin
      dnx_r  <= dnx[37:0];
      dny_r  <= dny[37:0];
      dnz_r  <= dnz[37:0];
      dden_r <= dl_q;
      dflg_r <= {edx[33], edy[33], edz[33], dnx[38], dny[38], dnz[38], dl_q == '0};
    end
  end

  chrg_div #(.NW(38), .DW(DL_RW), .QW(DQ_W)) u_ddiv_x (
    .clk (clk), .en (adv), .num (dnx_r), .den (dden_r), .quo (dqx)
  );
  chrg_div #(.NW(38), .DW(DL_RW), .QW(DQ_W)) u_ddiv_y (
    .clk (clk), .en (adv), .num (dny_r), .den (dden_r), .quo (dqy)
  );
  chrg_div #(.NW(38), .DW(DL_RW), .QW(DQ_W)) u_ddiv_z (
    .clk (clk), .en (adv), .num (dnz_r), .den (dden_r), .quo (dqz)
  );

  chrg_delay #(.W(7), .DEPTH(T_DQ - T_DN)) u_dflg_dly (
    .clk (clk), .en (adv), .d (dflg_r), .q (dflg_d)
  );

  chrg_delay #(.W(1), .DEPTH(T_DQ - T_SQ)) u_zn_dly (
    .clk (clk), .en (adv), .d (sq_r == '0), .q (zn_d)
  );

  chrg_delay #(.W(96), .DEPTH(T_DQ - T_P0)) u_pt_dly (
    .clk (clk), .en (adv), .d (pt_r), .q (pt_d)
  );

  assign pt_o = pt_d;

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      org_r    <= pt_o;
      ot_min_r <= t_min_r;
      ot_max_r <= t_max_r;
      zn_r     <= zn_d;
      if (zn_d || dflg_d[0]) begin
        dir_x_r <= '0;
        dir_y_r <= '0;
        dir_z_r <= '0;
      end else begin
        dir_x_r <= dir_sat(dqx, dflg_d[3], dflg_d[6]);
        dir_y_r <= dir_sat(dqy, dflg_d[2], dflg_d[5]);
        dir_z_r <= dir_sat(dqz, dflg_d[1], dflg_d[4]);
      end
    end
  end

  assign out_valid       = vld_r[T_OUT-1];
  assign out_origin_x    = org_r.x;
  assign out_origin_y    = org_r.y;
  assign out_origin_z    = org_r.z;
  assign out_dir_x       = dir_x_r;
  assign out_dir_y       = dir_y_r;
  assign out_dir_z       = dir_z_r;
  assign out_t_min       = ot_min_r;
  assign out_t_max       = ot_max_r;
  assign out_zero_normal = zn_r;

endmodule

[hw/rtl/chrg_delay.sv]
module chrg_delay #(
  parameter int W = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  // Shift line that advances with the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

[hw/rtl/chrg_isqrt.sv]
module chrg_isqrt #(
  parameter int W = 48
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     rad,
  output logic [W/2-1:0]   root
);

  localparam int RW = W / 2;
  localparam int XW = W + 2;

  logic [W-1:0]  rem_r  [RW];
  logic [RW-1:0] root_r [RW];

  // One root bit per stage, most significant first, restoring form.
  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int B = RW - 1 - k;
    logic [W-1:0]  rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (XW'(root_in) << (B + 1)) | (XW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (XW'(rem_in) >= trial) begin
          rem_r[k]  <= W'(XW'(rem_in) - trial);
          root_r[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

[hw/rtl/chrg_div.sv]
module chrg_div #(
  parameter int NW = 54,
  parameter int DW = 24,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  // One quotient bit per stage; the numerator must stay below den * 2^QW.
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [XW-1:0] sub;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign sub = XW'(den_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        if (XW'(rem_in) >= sub) begin
          rem_r[k] <= NW'(XW'(rem_in) - sub);
          quo_r[k] <= quo_in | (QW'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

[hw/rtl/chrg_cordic.sv]
module chrg_cordic
  import chrg_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  logic signed [31:0] x_r [N];
  logic signed [31:0] y_r [N];
  logic signed [31:0] z_r [N];
  logic [1:0]         quad_r [N];
  logic signed [31:0] cos_r, sin_r;

  // Rotation-mode micro-rotations, one per stage.
  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [31:0] x_in, y_in, z_in, xs, ys, at;
    logic [1:0]         quad_in;

    if (k == 0) begin : g_first
      assign x_in    = CORDIC_GAIN;
      assign y_in    = '0;
      assign z_in    = $signed({2'b00, angle[13:0], 16'h0000});
      assign quad_in = angle[15:14];
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign y_in    = y_r[k-1];
      assign z_in    = z_r[k-1];
      assign quad_in = quad_r[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;
    assign at = $signed({2'b00, ATAN_TURNS[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[k] <= quad_in;
        if (!z_in[31]) begin
          x_r[k] <= x_in - ys;
          y_r[k] <= y_in + xs;
          z_r[k] <= z_in - at;
        end else begin
          x_r[k] <= x_in + ys;
          y_r[k] <= y_in - xs;
          z_r[k] <= z_in + at;
        end
      end
    end
  end

  // Quadrant fold by multiples of a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad_r[N-1])
        QUAD_I: begin
          cos_r <= x_r[N-1];
          sin_r <= y_r[N-1];
        end
        QUAD_II: begin
          cos_r <= -y_r[N-1];
          sin_r <= x_r[N-1];
        end
        QUAD_III: begin
          cos_r <= -x_r[N-1];
          sin_r <= -y_r[N-1];
        end
        QUAD_IV: begin
          cos_r <= y_r[N-1];
          sin_r <= -x_r[N-1];
        end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[sim/cosine_hemisphere_ray_generator_test.sv]
module cosine_hemisphere_ray_generator_test;
  import chrg_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int PIPE_LATENCY = 141;
  localparam int PHASE_ITEMS = 347;
  localparam int NUM_DIRECTED = 18;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        ua, ue;
  } surface_hit_t;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic [30:0]        tmin, tmax;
    logic               zn;
  } ray_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic [15:0] in_uniform_angle, in_uniform_elevation;
  logic out_valid, out_stall;
  logic signed [31:0] out_origin_x, out_origin_y, out_origin_z;
  logic signed [15:0] out_dir_x, out_dir_y, out_dir_z;
  logic [30:0] out_t_min, out_t_max;
  logic out_zero_normal;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cosine_hemisphere_ray_generator dut (.*);

  // Local copy of the two distance registers.
  logic [30:0] t_min_reg, t_max_reg;
  ray_t pending_rays[$];
  int error_count = 0;
  bit pace_gaps, stall_busy;
  int stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= r + bits) begin
        v = v - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    return r;
  endfunction

  // Q.30 product, rounded to nearest with ties upward.
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Division rounded half away from zero; the divisor is positive.
  function automatic longint div_round(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] unit_component(longint d, longint len);
    longint q;
    q = div_round(d * 16, len);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Expected ray for one surface hit under the current registers.
  function automatic ray_t predict_ray(surface_hit_t h);
    ray_t r;
    longint vx, vy, vz, sq, len, nx, ny, nz, s, a, b;
    longint b1x, b1y, b1z, b2x, b2y, b2y_, b2z;
    longint cx, cy, cz, nxt, cp, sp, ct, st, tx, ty, ex, ey, ez, rx, ry, rz, dl;
    logic [1:0] quad;
    vx = h.nx;
    vy = h.ny;
    vz = h.nz;
    r.ox = h.px;
    r.oy = h.py;
    r.oz = h.pz;
    r.tmin = t_min_reg;
    r.tmax = t_max_reg;
    r.dx = 0;
    r.dy = 0;
    r.dz = 0;
    sq = vx * vx + vy * vy + vz * vz;
    r.zn = (sq == 0);
    if (sq == 0) return r;

    // Normalize and build the tangent basis.
    len = int_sqrt(sq << 16);
    nx = div_round(vx * (64'sd1 <<< 38), len);
    ny = div_round(vy * (64'sd1 <<< 38), len);
    nz = div_round(vz * (64'sd1 <<< 38), len);
    s = (nz >= 0) ? 1 : -1;
    a = -s * div_round(64'sd1 <<< 60, (64'sd1 <<< 30) + ((nz < 0) ? -nz : nz));
    b = qmul(qmul(nx, ny), a);
    b1x = (64'sd1 <<< 30) + s * qmul(qmul(nx, nx), a);
    b1y = s * b;
    b1z = -s * nx;
    b2x = b;
    b2y_ = s * (64'sd1 <<< 30) + qmul(qmul(ny, ny), a);
    b2z = -ny;

    // Azimuth by rotation-mode CORDIC, then quadrant fold.
    quad = h.ua[15:14];
    cz = (longint'(h.ua) << 16) & 64'h3FFFFFFF;
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
      if (cz >= 0) begin
        nxt = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - longint'(ATAN_TURNS[i]);
      end else begin
        nxt = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + longint'(ATAN_TURNS[i]);
      end
      cx = nxt;
    end
    case (quad)
      2'd0: begin cp = cx;  sp = cy;  end
      2'd1: begin cp = -cy; sp = cx;  end
      2'd2: begin cp = -cx; sp = -cy; end
      default: begin cp = cy; sp = -cx; end
    endcase

    // Elevation, rotation into world space and renormalization.
    ct = int_sqrt(longint'(h.ue) << 44);
    st = int_sqrt((65536 - longint'(h.ue)) << 44);
    tx = qmul(st, cp);
    ty = qmul(st, sp);
    ex = qmul(tx, b1x) + qmul(ty, b2x) + qmul(ct, nx);
    ey = qmul(tx, b1y) + qmul(ty, b2y_) + qmul(ct, ny);
    ez = qmul(tx, b1z) + qmul(ty, b2z) + qmul(ct, nz);
    rx = (ex + 512) >>> 10;
    ry = (ey + 512) >>> 10;
    rz = (ez + 512) >>> 10;
    dl = int_sqrt(rx * rx + ry * ry + rz * rz);
    if (dl > 0) begin
      r.dx = unit_component(ex, dl);
      r.dy = unit_component(ey, dl);
      r.dz = unit_component(ez, dl);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] random_normal_comp(int kind);
    case (kind)
      0: return 16'($signed($urandom_range(0, 6)) - 3);
      1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic surface_hit_t random_hit();
    surface_hit_t h;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind > 1) kind = 2;
    h.px = $urandom;
    h.py = $urandom;
    h.pz = $urandom;
    h.nx = random_normal_comp(kind);
    h.ny = random_normal_comp(kind);
    h.nz = random_normal_comp(kind);
    // Now and then an axis-aligned normal.
    if ($urandom_range(0, 11) == 0) begin
      h.nx = 0;
      h.ny = 0;
    end
    h.ua = $urandom;
    h.ue = $urandom;
    return h;
  endfunction

  // Present one hit and wait until the block takes the beat.
  task automatic send_hit(surface_hit_t h, ray_t expected);
    int gap;
    gap = 0;
    if (pace_gaps)
      gap = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= h.px;
    in_point_y <= h.py;
    in_point_z <= h.pz;
    in_normal_x <= h.nx;
    in_normal_y <= h.ny;
    in_normal_z <= h.nz;
    in_uniform_angle <= h.ua;
    in_uniform_elevation <= h.ue;
    do @(posedge clk); while (in_stall);
    pending_rays.insert(pending_rays.size(), expected);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_T_MIN) t_min_reg = data[30:0];
    else if (idx == REG_T_MAX) t_max_reg = data[30:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 20) @(posedge clk);
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      error_count++;
    end
  endtask

  // Output stall: bursts of random length, most short and a few long.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_busy) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    end
  end

  // Compare every accepted output beat with the oldest pending ray.
  always @(posedge clk) begin
    ray_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rays.size() == 0) begin
        $error("output beat with no ray pending");
        error_count++;
      end else begin
        e = pending_rays.pop_front();
        check_field("origin_x", e.ox, out_origin_x);
        check_field("origin_y", e.oy, out_origin_y);
        check_field("origin_z", e.oz, out_origin_z);
        check_field("dir_x", e.dx, out_dir_x);
        check_field("dir_y", e.dy, out_dir_y);
        check_field("dir_z", e.dz, out_dir_z);
        check_field("t_min", e.tmin, out_t_min);
        check_field("t_max", e.tmax, out_t_max);
        check_field("zero_normal", e.zn, out_zero_normal);
      end
    end
  end

  initial begin
    surface_hit_t directed_hits[NUM_DIRECTED];
    bit zero_rows[NUM_DIRECTED];
    surface_hit_t h;
    ray_t e;

    // Point extremes, zero normals, axis and extreme normals, quadrant edges.
    directed_hits = '{
      '{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 16'd0, 16'd0},
      '{-1, 1, 12345, 0, 0, 0, 16'hFFFF, 16'hFFFF},
      '{0, 0, 0, 0, 0, 16384, 16'd0, 16'd0},
      '{5, 6, 7, 0, 0, 16384, 16'd0, 16'hFFFF},
      '{-5, -6, -7, 0, 0, -16384, 16'd16384, 16'd32768},
      '{100, 0, 0, 16384, 0, 0, 16'd32768, 16'd0},
      '{0, 100, 0, 0, 16384, 0, 16'd49152, 16'd32768},
      '{0, 0, 100, -32768, -32768, -32768, 16'd49152, 16'd100},
      '{32'sh80000000, 32'sh7FFFFFFF, -1, 32767, 32767, 32767, 16'hFFFF, 16'hFFFF},
      '{1, 2, 3, 1, 0, 0, 16'h1234, 16'h8000},
      '{4, 5, 6, 0, 0, -1, 16'd16383, 16'd1},
      '{7, 8, 9, -32768, 32767, 0, 16'd49151, 16'd32767},
      '{0, 0, 0, 0, 0, 32767, 16'd16385, 16'hFFFE},
      '{0, 0, 0, 0, 0, -32768, 16'd32769, 16'd2},
      '{65536, -65536, 3, 300, -200, -5, 16'd8192, 16'd40000},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, -1, -1, -1, 16'd777, 16'd50000},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32768, 0, 0, 16'd24576, 16'd20000},
      '{0, 0, 0, 0, -32768, 0, 16'd40960, 16'd60000}
    };
    zero_rows = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    in_normal_x <= '0;
    in_normal_y <= '0;
    in_normal_z <= '0;
    in_uniform_angle <= '0;
    in_uniform_elevation <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_T_MIN;
    cfg_data <= '0;
    t_min_reg = T_MIN_RST;
    t_max_reg = T_MAX_RST;
    pace_gaps = 1'b1;
    stall_busy = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; a zero normal has an obvious result.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      h = directed_hits[i];
      if (zero_rows[i])
        e = '{h.px, h.py, h.pz, 16'sd0, 16'sd0, 16'sd0, t_min_reg, t_max_reg, 1'b1};
      else
        e = predict_ray(h);
      send_hit(h, e);
    end
    drain();

    // Random phases under different register settings and pacing.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(REG_T_MIN, 32'd0);
          write_reg(REG_T_MAX, 32'hFFFFFFFF);
        end
        1: begin
          write_reg(REG_T_MIN, 32'h7FFFFFFF);
          write_reg(REG_T_MAX, 32'h80000000);
        end
        2: begin
          write_reg(REG_T_MIN, $urandom);
          write_reg(REG_T_MAX, $urandom);
          write_reg(REG_SPARE_2, $urandom);
          write_reg(REG_SPARE_3, $urandom);
        end
        3: begin
          write_reg(REG_T_MAX, $urandom);
          write_reg(REG_T_MIN, $urandom);
        end
        default: begin
          write_reg(REG_T_MIN, 32'(T_MIN_RST));
          write_reg(REG_T_MAX, 32'(T_MAX_RST));
        end
      endcase
      pace_gaps = (p != 1);
      stall_busy = (p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        h = random_hit();
        send_hit(h, predict_ray(h));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
